// File: rtl/core/ralu_pkg.sv
// ----------------------------------------------------------------------------
// ralu_pkg
// Shared types, opcodes and constants for the rational ALU.
// ----------------------------------------------------------------------------
package ralu_pkg;

  localparam int DefWidth = 32;

  // opcodes
  localparam logic [2:0] CMD_MAKE = 3'd0;
  localparam logic [2:0] CMD_ADD  = 3'd1;
  localparam logic [2:0] CMD_SUB  = 3'd2;
  localparam logic [2:0] CMD_MUL  = 3'd3;
  localparam logic [2:0] CMD_DIV  = 3'd4;

  // datapath operations
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_LOADX  = 3'd1;
  localparam logic [2:0] OP_LOADY  = 3'd2;
  localparam logic [2:0] OP_LOADR  = 3'd3;
  localparam logic [2:0] OP_GCDST  = 3'd4;
  localparam logic [2:0] OP_GCDSTP = 3'd5;
  localparam logic [2:0] OP_DIVST  = 3'd6;
  localparam logic [2:0] OP_DIVSTP = 3'd7;

  typedef struct packed {
    logic [2:0]  cmd;
    logic signed [31:0] x_num;
    logic signed [31:0] x_den;
    logic signed [31:0] y_num;
    logic signed [31:0] y_den;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0] res_den;
    logic        status;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic [2:0] op;
    logic [1:0] sel;   // which fraction a store acts on
    logic       clr;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic zero_den;
    logic zero_num;
    logic gcd_done;
    logic div_done;
  } dp_stat_t;

endpackage

// File: rtl/core/rational_alu_with_gcd_reduce.sv
// ----------------------------------------------------------------------------
// rational_alu_with_gcd_reduce
// Exact rational ALU with reduction to lowest terms.
// ----------------------------------------------------------------------------
// Sequence: each reduction runs the Euclid remainder steps, then divides the
// numerator and denominator by the gcd (a zero numerator gives 0/1 directly);
// make runs one reduction, the other opcodes three, between load and output.
// Throughput: one item at a time; the next is taken once the result leaves.
// Reset: rst clears the sequencer to idle; operand registers are not reset.
module rational_alu_with_gcd_reduce #(
  parameter int WIDTH = ralu_pkg::DefWidth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ralu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ralu_pkg::out_item_t out_data
);
  import ralu_pkg::*;

  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  ralu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_data.cmd), .out_valid(out_valid), .out_stall(out_stall),
    .stat(dstat), .cmd(dcmd)
  );

  ralu_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk(clk), .in_item(in_data), .cmd(dcmd), .stat(dstat), .res(out_data)
  );

endmodule

// File: rtl/core/ralu_datapath.sv
// ----------------------------------------------------------------------------
// ralu_datapath
// Operand registers, wrapping products, remainder GCD and quotient units.
// ----------------------------------------------------------------------------
module ralu_datapath #(
  parameter int WIDTH = ralu_pkg::DefWidth
) (
  input  logic               clk,
  input  ralu_pkg::in_item_t in_item,
  input  ralu_pkg::dp_cmd_t  cmd,
  output ralu_pkg::dp_stat_t stat,
  output ralu_pkg::out_item_t res
);
  import ralu_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] xn, xd, yn, yd, an, ad;   // an/ad: fraction being reduced
  logic [WIDTH-1:0] ga, gb;                    // gcd operands
  logic [WIDTH-1:0] q, rem, dvs, dvd;          // restoring division
  logic [CW-1:0]    bitc;
  logic             gmode;                     // division serves the gcd
  logic [WIDTH-1:0] qn;
  logic             neg;
  logic [2:0]       opc;
  logic             err;

  function automatic logic [WIDTH-1:0] f_mag(input logic [WIDTH-1:0] v);
    return v[WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [WIDTH-1:0] f_in(input logic [31:0] v);
    logic [63:0] e;
    e = {{32{v[31]}}, v};
    return e[WIDTH-1:0];
  endfunction

  // wrapping products, one multiplication set per cycle
  logic [WIDTH-1:0] p1, p2, p3;
  logic [2*WIDTH-1:0] m1, m2, m3;
  always_comb begin
    m1 = xn * yd;
    m2 = yn * xd;
    m3 = xd * yd;
    unique case (opc)
      CMD_MUL: begin
        m1 = xn * yn;
      end
      CMD_DIV: begin
        m3 = xd * yn;
      end
      default: begin
      end
    endcase
    p1 = m1[WIDTH-1:0];
    p2 = m2[WIDTH-1:0];
    p3 = m3[WIDTH-1:0];
  end

  // one restoring division step
  logic [WIDTH:0]   trial;
  logic [WIDTH-1:0] rsh;
  always_comb begin
    rsh   = {rem[WIDTH-2:0], dvd[WIDTH-1]};
    trial = {rem[WIDTH-1], rsh} - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      err <= 1'b0;
    end
    case (cmd.op)
      OP_LOADX: begin
        // capture item, start reducing x
        opc <= in_item.cmd;
        an  <= f_in(in_item.x_num);
        ad  <= f_in(in_item.x_den);
        yn  <= f_in(in_item.y_num);
        yd  <= f_in(in_item.y_den);
      end
      OP_LOADY: begin
        an <= yn;
        ad <= yd;
      end
      OP_LOADR: begin
        unique case (opc)
          CMD_ADD: an <= p1 + p2;
          CMD_SUB: an <= p1 - p2;
          default: an <= p1;
        endcase
        ad <= p3;
        if (opc == CMD_DIV && yn == '0) err <= 1'b1;
      end
      OP_GCDST: begin
        // gcd init: a=|num|, b=|den|
        ga <= f_mag(an);
        gb <= f_mag(ad);
        neg <= an[WIDTH-1] ^ ad[WIDTH-1];
        gmode <= 1'b1;
        dvd <= f_mag(an);
        dvs <= f_mag(ad);
        rem <= '0;
        bitc <= CW'(WIDTH);
      end
      OP_GCDSTP: begin
        if (bitc != '0) begin
          rem  <= trial[WIDTH] ? rsh : trial[WIDTH-1:0];
          dvd  <= {dvd[WIDTH-2:0], 1'b0};
          bitc <= bitc - 1'b1;
        end else if (gb != '0) begin
          // advance euclid: (a,b) <- (b, a mod b)
          ga   <= gb;
          gb   <= rem;
          dvd  <= gb;
          dvs  <= rem;
          rem  <= '0;
          bitc <= CW'(WIDTH);
        end
      end
      OP_DIVST: begin
        dvd <= f_mag(an);
        dvs <= ga;
        rem <= '0;
        q   <= '0;
        bitc <= CW'(WIDTH);
        gmode <= 1'b0;
      end
      OP_DIVSTP: begin
        if (bitc != '0) begin
          rem  <= trial[WIDTH] ? rsh : trial[WIDTH-1:0];
          q    <= {q[WIDTH-2:0], ~trial[WIDTH]};
          dvd  <= {dvd[WIDTH-2:0], 1'b0};
          bitc <= bitc - 1'b1;
        end else if (cmd.sel == 2'd0) begin
          // numerator quotient done, start denominator
          qn   <= q;
          dvd  <= f_mag(ad);
          rem  <= '0;
          q    <= '0;
          bitc <= CW'(WIDTH);
        end else begin
          // store reduced fraction into x, y or result
          case (cmd.sel)
            2'd1: begin
              xn <= neg ? (~qn + 1'b1) : qn;
              xd <= q;
            end
            2'd2: begin
              yn <= neg ? (~qn + 1'b1) : qn;
              yd <= q;
            end
            default: begin
              an <= neg ? (~qn + 1'b1) : qn;
              ad <= q;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
    // zero-numerator shortcut stores 0/1
    if (cmd.op == OP_NONE && cmd.sel != 2'd0) begin
      case (cmd.sel)
        2'd1: begin
          xn <= '0;
          xd <= WIDTH'(1);
        end
        2'd2: begin
          yn <= '0;
          yd <= WIDTH'(1);
        end
        default: begin
          an <= '0;
          ad <= WIDTH'(1);
        end
      endcase
    end
    if (cmd.op == OP_NONE && cmd.clr == 1'b0 && cmd.sel == 2'd0 && stat.zero_den) begin
      err <= err;
    end
  end

  assign stat.zero_den = (ad == '0);
  assign stat.zero_num = (an == '0);
  assign stat.gcd_done = (bitc == '0) && (gb == '0) && gmode;
  assign stat.div_done = (bitc == '0);

  // output: error gives 0/1
  logic [63:0] on, od;
  always_comb begin
    on = {{(64-WIDTH){an[WIDTH-1]}}, an};
    od = {{(64-WIDTH){ad[WIDTH-1]}}, ad};
    if (err || ad == '0) begin
      res.res_num = '0;
      res.res_den = 31'd1;
      res.status  = 1'b1;
    end else begin
      res.res_num = on[31:0];
      res.res_den = od[30:0];
      res.status  = 1'b0;
    end
  end

endmodule

// File: rtl/core/ralu_ctrl.sv
// ----------------------------------------------------------------------------
// ralu_ctrl
// Sequencer: reduce x, reduce y, form raw result, reduce it, deliver (make reduces x only).
// ----------------------------------------------------------------------------
module ralu_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_cmd,
  output logic               out_valid,
  input  logic               out_stall,
  input  ralu_pkg::dp_stat_t stat,
  output ralu_pkg::dp_cmd_t  cmd
);
  import ralu_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_GCD  = 3'd2;
  localparam logic [2:0] S_DIVS = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_NEXT = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state, state_next;
  logic [1:0] phase, phase_next;   // 1 x, 2 y, 3 result
  logic       dsel, dsel_next;     // 0 numerator, 1 denominator

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    phase_next = phase;
    dsel_next  = dsel;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op  = OP_LOADX;
          cmd.clr = 1'b1;
          // make reduces x straight into the result registers
          if ((in_cmd == CMD_ADD) || (in_cmd == CMD_SUB) ||
              (in_cmd == CMD_MUL) || (in_cmd == CMD_DIV)) begin
            phase_next = 2'd1;
          end else begin
            phase_next = 2'd3;
          end
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.zero_den) begin
          // zero denominator ends the item with error shown
          state_next = S_OUT;
        end else if (stat.zero_num) begin
          cmd.sel = phase;
          state_next = S_NEXT;
        end else begin
          cmd.op = OP_GCDST;
          state_next = S_GCD;
        end
      end
      S_GCD: begin
        cmd.op = OP_GCDSTP;
        if (stat.gcd_done) begin
          state_next = S_DIVS;
        end
      end
      S_DIVS: begin
        cmd.op = OP_DIVST;
        dsel_next = 1'b0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIVSTP;
        if (stat.div_done) begin
          if (!dsel) begin
            dsel_next = 1'b1;
          end else begin
            cmd.sel = phase;
            state_next = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        if (phase == 2'd1) begin
          cmd.op = OP_LOADY;
          phase_next = 2'd2;
          state_next = S_CHK;
        end else if (phase == 2'd2) begin
          cmd.op = OP_LOADR;
          phase_next = 2'd3;
          state_next = S_CHK;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // for cmd.sel the divider unit uses 0 while numerator still runs
    if (state == S_DIV && !(stat.div_done && dsel)) begin
      cmd.sel = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 2'd0;
      dsel  <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      dsel  <= dsel_next;
    end
  end

endmodule

// File: rtl/core/ralu_checker.sv
// ----------------------------------------------------------------------------
// ralu_checker
// Port-level checks for the rational ALU.
// ----------------------------------------------------------------------------
module ralu_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input ralu_pkg::out_item_t out_data
);
  import ralu_pkg::*;

  // no item taken while a result is pending
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open with result pending");

  // error result is always 0/1
  a_err: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status) |-> (out_data.res_num == 0 && out_data.res_den == 1))
    else $error("error result not 0/1");

  // held result does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // accepted item does not produce a result at once
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !out_valid) else $error("result too early");

endmodule

bind rational_alu_with_gcd_reduce ralu_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
